### rtl/core/clcd_pkg.sv
// shared types and constants for the character lcd command sequencer
package clcd_pkg;

  localparam int unsigned LINE_WIDTH_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned CFG_IDX_W       = 8;

  localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
  localparam logic [6:0] ROW1_BASE        = 7'h40;

  localparam logic [7:0] POWER_UP_WAIT_RST = 8'd40;
  localparam logic [7:0] CMD_SETTLE_RST    = 8'd5;
  localparam logic [7:0] CLEAR_SETTLE_RST  = 8'd20;
  localparam logic [7:0] PULSE_RST         = 8'd40;

  localparam logic [2:0] INIT_LAST_STEP = 3'd4;
  localparam logic [2:0] INIT_DISP_STEP = 3'd3;

  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_CHAR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_POWER_UP     = 2'd0,
    CFG_CMD_SETTLE   = 2'd1,
    CFG_CLEAR_SETTLE = 2'd2,
    CFG_PULSE        = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] addr;
    logic [7:0] glyph;
  } cmd_t;

endpackage

### rtl/core/clcd_req_if.sv
// request channel: one display request per item
interface clcd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       row;
  logic [3:0] column;
  logic [7:0] glyph;
  logic       first;

  modport source (output valid, kind, row, column, glyph, first, input ready);
  modport sink   (input valid, kind, row, column, glyph, first, output ready);
endinterface

### rtl/core/clcd_xfer_if.sv
// transfer channel: one lcd bus transfer per item
interface clcd_xfer_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [7:0] bus_byte;
  logic [7:0] strobe_us;
  logic [7:0] wait_before_ms;
  logic [7:0] wait_after_ms;
  logic       last;

  modport source (output valid, reg_select, bus_byte, strobe_us, wait_before_ms,
                  wait_after_ms, last, input ready);
  modport sink   (input valid, reg_select, bus_byte, strobe_us, wait_before_ms,
                  wait_after_ms, last, output ready);
endinterface

### rtl/core/clcd_cfg_if.sv
// configuration write channel
interface clcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/char_lcd_command_sequencer.sv
// top level of the character lcd command sequencer
// an item's first transfer passes through the command queue, then the output register
// throughput: one transfer per cycle from the output register while a command waits
//   and the sink is ready; a request item is taken each cycle the queue has room
// reset: queue and output empty, cursor at row 0 column 0, config registers
//   power up 40, command settle 5, clear settle 20, enable pulse 40
module char_lcd_command_sequencer #(
  parameter int unsigned LINE_WIDTH  = clcd_pkg::LINE_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  clcd_req_if.sink    req_i,
  clcd_cfg_if.sink    cfg_i,
  clcd_xfer_if.source xfer_o
);
  import clcd_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  clcd_front #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  clcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty)
  );

  clcd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg     (cfg_i),
    .cmd_i   (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .xfer    (xfer_o)
  );

endmodule

### rtl/core/clcd_front.sv
// request front end: accepts items, tracks the cursor, queues commands
module clcd_front #(
  parameter int unsigned LINE_WIDTH = clcd_pkg::LINE_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  clcd_req_if.sink       req,
  input  logic           full_i,
  output logic           push_o,
  output clcd_pkg::cmd_t cmd_o
);
  import clcd_pkg::*;

  localparam int unsigned COL_W = ($clog2(LINE_WIDTH) > 4) ? $clog2(LINE_WIDTH) : 4;

  logic             row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             accept;
  logic             is_char;
  logic             cur_row;
  logic [COL_W-1:0] cur_col;
  logic [COL_W:0]   col_inc;
  logic [COL_W:0]   col_wrap;
  logic [6:0]       addr;

  assign req.ready = !full_i;
  assign accept    = req.valid && req.ready;
  assign is_char   = (req.kind == KIND_CHAR);

  assign cur_row  = req.first ? req.row : row_q;
  assign cur_col  = req.first ? COL_W'(req.column) : col_q;
  assign addr     = (cur_row ? ROW1_BASE : 7'd0) + 7'(cur_col);
  assign col_inc  = {1'b0, cur_col} + (COL_W+1)'(1);
  // a loaded column may lie past a short line, so up to two wraps
  assign col_wrap = (32'(col_inc) >= 2 * LINE_WIDTH) ?
                    col_inc - (COL_W+1)'(2 * LINE_WIDTH) :
                    (col_inc >= (COL_W+1)'(LINE_WIDTH)) ?
                    col_inc - (COL_W+1)'(LINE_WIDTH) : col_inc;

  always_comb begin
    push_o      = accept && (req.kind inside {KIND_INIT, KIND_CLEAR, KIND_CHAR});
    cmd_o.kind  = kind_e'(req.kind);
    cmd_o.addr  = addr;
    cmd_o.glyph = req.glyph;
    row_d       = row_q;
    col_d       = col_q;
    if (accept && is_char) begin
      row_d = cur_row;
      col_d = col_wrap[COL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 1'b0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

### rtl/core/clcd_queue.sv
// command queue between the front end and the transfer sequencer
module clcd_queue #(
  parameter int unsigned DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clcd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output clcd_pkg::cmd_t cmd_o,
  output logic           empty_o
);
  import clcd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

### rtl/core/clcd_back.sv
// transfer sequencer: expands queued commands into bus transfers, holds config
module clcd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  clcd_cfg_if.sink       cfg,
  input  clcd_pkg::cmd_t cmd_i,
  input  logic           empty_i,
  output logic           pop_o,
  clcd_xfer_if.source    xfer
);
  import clcd_pkg::*;

  logic [7:0] power_up_q;
  logic [7:0] cmd_settle_q;
  logic [7:0] clear_settle_q;
  logic [7:0] pulse_q;

  logic [2:0] step_q, step_d;
  logic       valid_q, valid_d;
  logic       rs_q;
  logic [7:0] byte_q;
  logic [7:0] strobe_q;
  logic [7:0] before_q;
  logic [7:0] after_q;
  logic       last_q;

  logic       load;
  logic       rs_d;
  logic [7:0] byte_d;
  logic [7:0] before_d;
  logic [7:0] after_d;
  logic       last_d;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_up_q     <= POWER_UP_WAIT_RST;
      cmd_settle_q   <= CMD_SETTLE_RST;
      clear_settle_q <= CLEAR_SETTLE_RST;
      pulse_q        <= PULSE_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_IDX_W'(CFG_POWER_UP):     power_up_q     <= cfg.data;
        CFG_IDX_W'(CFG_CMD_SETTLE):   cmd_settle_q   <= cfg.data;
        CFG_IDX_W'(CFG_CLEAR_SETTLE): clear_settle_q <= cfg.data;
        CFG_IDX_W'(CFG_PULSE):        pulse_q        <= cfg.data;
        default: ;
      endcase
    end
  end

  assign load = !empty_i && (!valid_q || xfer.ready);

  always_comb begin
    rs_d     = 1'b0;
    byte_d   = CMD_CLEAR;
    before_d = 8'd0;
    after_d  = 8'd0;
    last_d   = 1'b1;
    case (cmd_i.kind)
      KIND_INIT: begin
        last_d = (step_q == INIT_LAST_STEP);
        if (step_q == '0) begin
          before_d = power_up_q;
        end
        if (step_q == INIT_LAST_STEP) begin
          byte_d  = CMD_CLEAR;
          after_d = clear_settle_q;
        end else if (step_q == INIT_DISP_STEP) begin
          byte_d  = CMD_DISPLAY_ON;
          after_d = cmd_settle_q;
        end else begin
          byte_d  = CMD_FUNCTION_SET;
          after_d = cmd_settle_q;
        end
      end
      KIND_CLEAR: begin
        byte_d  = CMD_CLEAR;
        after_d = clear_settle_q;
      end
      KIND_CHAR: begin
        if (step_q == '0) begin
          byte_d = CMD_SET_ADDR | {1'b0, cmd_i.addr};
          last_d = 1'b0;
        end else begin
          rs_d   = 1'b1;
          byte_d = cmd_i.glyph;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    pop_o   = load && last_d;
    step_d  = step_q;
    valid_d = valid_q && !xfer.ready;
    if (load) begin
      valid_d = 1'b1;
      step_d  = last_d ? '0 : step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rs_q     <= rs_d;
      byte_q   <= byte_d;
      strobe_q <= (pulse_q == 8'd0) ? 8'd1 : pulse_q;
      before_q <= before_d;
      after_q  <= after_d;
      last_q   <= last_d;
    end
  end

  assign xfer.valid          = valid_q;
  assign xfer.reg_select     = rs_q;
  assign xfer.bus_byte       = byte_q;
  assign xfer.strobe_us      = strobe_q;
  assign xfer.wait_before_ms = before_q;
  assign xfer.wait_after_ms  = after_q;
  assign xfer.last           = last_q;

  a_data_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer.valid && xfer.reg_select |-> xfer.last)
    else $error("data byte not last transfer");

  a_strobe_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer.valid |-> xfer.strobe_us != 8'd0)
    else $error("zero strobe width");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= INIT_LAST_STEP)
    else $error("step counter out of range");

  a_char_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i && cmd_i.kind == KIND_CHAR |-> step_q <= 3'd1)
    else $error("character command beyond two steps");

endmodule
